[sv/fcl_pkg.sv]
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared types and codes of the fingerprint cache.
// ----------------------------------------------------------------------------
`default_nettype none

package fcl_pkg;

  typedef enum logic [2:0] {
    OUT_MISS_SKIP   = 3'd0,
    OUT_MISS_COMMIT = 3'd1,
    OUT_HIT_INTER   = 3'd2,
    OUT_HIT_SAME    = 3'd3,
    OUT_HIT_INTRA   = 3'd4
  } outcome_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_MV1,
    S_MV2,
    S_MV3,
    S_MISS,
    S_EV1,
    S_EV2,
    S_EV3,
    S_INS1,
    S_INS2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [63:0] signature;
    logic [15:0] packet_tag;
    logic [15:0] byte_offset;
    logic        first_window;
  } item_t;

  typedef struct packed {
    logic [63:0] signature;
    logic [15:0] tag;
    logic [15:0] offset;
    logic [31:0] hits;
  } rec_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [15:0] match_tag;
    logic [15:0] match_offset;
    logic [31:0] match_hits;
    logic        evicted;
    logic [15:0] evicted_tag;
    logic [31:0] evicted_hits;
  } res_t;

endpackage

`default_nettype wire

[sv/fcl_front.sv]
// ----------------------------------------------------------------------------
// fcl_front
// Input stage: takes items and holds them in a two-entry queue for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fcl_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire fcl_pkg::item_t in_item_i,
  input  wire logic          clearing_i,
  output logic               q_valid_o,
  output fcl_pkg::item_t     q_item_o,
  input  wire logic          q_pop_i
);

  fcl_pkg::item_t q_mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2) && !clearing_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (q_pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/fcl_back.sv]
// ----------------------------------------------------------------------------
// fcl_back
// Table engine: bucket chains, recency list, commit and eviction sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fcl_back #(
  parameter int ENTRIES = 1024,
  parameter int BUCKETS = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [15:0]    min_gap_i,
  input  wire logic           q_valid_i,
  input  wire fcl_pkg::item_t q_item_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output fcl_pkg::res_t       out_res_o
);

  localparam int SW  = $clog2(ENTRIES);
  localparam int PW  = SW + 1;
  localparam int BIX = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [BIX:0]   BK      = BUCKETS[BIX:0];
  localparam logic [BIX-1:0] BLAST   = BIX'(BUCKETS - 1);
  localparam logic [SW:0]    CNT_MAX = ENTRIES[SW:0];
  localparam logic [PW-1:0]  NULLP   = {1'b1, {SW{1'b0}}};

  function automatic logic [BIX-1:0] bucket_of(input logic [63:0] s);
    logic [BIX:0] lo;
    lo = {1'b0, s[BIX-1:0]};
    if (lo >= BK) begin
      lo = lo - BK;
    end
    return lo[BIX-1:0];
  endfunction

  // memories
  fcl_pkg::rec_t rec_mem [ENTRIES];
  logic [PW-1:0] bn_mem  [ENTRIES];
  logic [PW-1:0] lp_mem  [ENTRIES];
  logic [PW-1:0] ln_mem  [ENTRIES];
  logic [PW-1:0] bh_mem  [BUCKETS];

  fcl_pkg::rec_t rec_rd_q;
  logic [PW-1:0] bn_rd_q, lp_rd_q, ln_rd_q, bh_rd_q;

  logic [SW-1:0]  rd_addr;
  logic [BIX-1:0] bh_ra;

  logic           rec_we;
  logic [SW-1:0]  rec_wa;
  fcl_pkg::rec_t  rec_wd;
  logic           bn_we, lp_we, ln_we, bh_we;
  logic [SW-1:0]  bn_wa, lp_wa, ln_wa;
  logic [BIX-1:0] bh_wa;
  logic [PW-1:0]  bn_wd, lp_wd, ln_wd, bh_wd;

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    if (bn_we) begin
      bn_mem[bn_wa] <= bn_wd;
    end
    if (lp_we) begin
      lp_mem[lp_wa] <= lp_wd;
    end
    if (ln_we) begin
      ln_mem[ln_wa] <= ln_wd;
    end
    if (bh_we) begin
      bh_mem[bh_wa] <= bh_wd;
    end
    rec_rd_q <= rec_mem[rd_addr];
    bn_rd_q  <= bn_mem[rd_addr];
    lp_rd_q  <= lp_mem[rd_addr];
    ln_rd_q  <= ln_mem[rd_addr];
    bh_rd_q  <= bh_mem[bh_ra];
  end

  // control state
  fcl_pkg::state_e state_q, state_d;
  fcl_pkg::item_t  it_q, it_d;
  logic [BIX-1:0]  bkt_q, bkt_d, evb_q, evb_d, clr_q, clr_d;
  logic [PW-1:0]   ptr_q, ptr_d, lp_q, lp_d, ln_q, ln_d, evn_q, evn_d;
  logic [PW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [SW-1:0]   slot_q, slot_d;
  logic [SW:0]     cnt_q, cnt_d;
  logic [15:0]     lco_q, lco_d;
  logic            cip_q, cip_d;
  fcl_pkg::res_t   res_q, res_d, out_q, out_d;
  logic            ov_q, ov_d;
  logic            commit;
  logic [31:0]     hits_n;
  logic [15:0]     gap_dist;

  assign clearing_o  = (state_q == fcl_pkg::S_CLEAR);
  assign out_valid_o = ov_q;
  assign out_res_o   = out_q;
  assign gap_dist    = it_q.byte_offset - lco_q;
  assign hits_n      = (rec_rd_q.hits == 32'hFFFF_FFFF) ? rec_rd_q.hits
                                                        : rec_rd_q.hits + 32'd1;

  always_comb begin
    if (!cip_q) begin
      commit = 1'b1;
    end else if (it_q.byte_offset >= lco_q) begin
      commit = (gap_dist >= min_gap_i);
    end else begin
      commit = (min_gap_i == 16'd0);
    end
  end

  always_comb begin
    state_d = state_q;
    it_d    = it_q;
    bkt_d   = bkt_q;
    evb_d   = evb_q;
    clr_d   = clr_q;
    ptr_d   = ptr_q;
    lp_d    = lp_q;
    ln_d    = ln_q;
    evn_d   = evn_q;
    head_d  = head_q;
    tail_d  = tail_q;
    slot_d  = slot_q;
    cnt_d   = cnt_q;
    lco_d   = lco_q;
    cip_d   = cip_q;
    res_d   = res_q;
    out_d   = out_q;
    ov_d    = ov_q && !out_ready_i;
    q_pop_o = 1'b0;
    rd_addr = ptr_q[SW-1:0];
    bh_ra   = bkt_q;
    rec_we  = 1'b0;
    rec_wa  = slot_q;
    rec_wd  = rec_rd_q;
    bn_we   = 1'b0;
    bn_wa   = slot_q;
    bn_wd   = NULLP;
    lp_we   = 1'b0;
    lp_wa   = slot_q;
    lp_wd   = NULLP;
    ln_we   = 1'b0;
    ln_wa   = slot_q;
    ln_wd   = NULLP;
    bh_we   = 1'b0;
    bh_wa   = bkt_q;
    bh_wd   = NULLP;

    unique case (state_q)
      fcl_pkg::S_CLEAR: begin
        bh_we = 1'b1;
        bh_wa = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == BLAST) begin
          state_d = fcl_pkg::S_IDLE;
        end
      end
      fcl_pkg::S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          it_d    = q_item_i;
          bkt_d   = bucket_of(q_item_i.signature);
          bh_ra   = bkt_d;
          res_d   = '0;
          if (q_item_i.first_window) begin
            cip_d = 1'b0;
          end
          state_d = fcl_pkg::S_HEAD;
        end
      end
      fcl_pkg::S_HEAD: begin
        ptr_d   = bh_rd_q;
        rd_addr = bh_rd_q[SW-1:0];
        state_d = bh_rd_q[SW] ? fcl_pkg::S_MISS : fcl_pkg::S_WALK;
      end
      fcl_pkg::S_WALK: begin
        if (rec_rd_q.signature == it_q.signature) begin
          slot_d             = ptr_q[SW-1:0];
          lp_d               = lp_rd_q;
          ln_d               = ln_rd_q;
          res_d.match_tag    = rec_rd_q.tag;
          res_d.match_offset = rec_rd_q.offset;
          if (rec_rd_q.tag == it_q.packet_tag) begin
            res_d.match_hits = rec_rd_q.hits;
            res_d.outcome    = (rec_rd_q.offset == it_q.byte_offset) ?
                               fcl_pkg::OUT_HIT_SAME : fcl_pkg::OUT_HIT_INTRA;
            state_d          = fcl_pkg::S_DONE;
          end else begin
            rec_we           = 1'b1;
            rec_wa           = ptr_q[SW-1:0];
            rec_wd           = rec_rd_q;
            rec_wd.hits      = hits_n;
            res_d.match_hits = hits_n;
            res_d.outcome    = fcl_pkg::OUT_HIT_INTER;
            state_d = (ptr_q == tail_q) ? fcl_pkg::S_DONE : fcl_pkg::S_MV1;
          end
        end else if (bn_rd_q[SW]) begin
          state_d = fcl_pkg::S_MISS;
        end else begin
          ptr_d   = bn_rd_q;
          rd_addr = bn_rd_q[SW-1:0];
        end
      end
      fcl_pkg::S_MV1: begin
        if (lp_q[SW]) begin
          head_d = ln_q;
        end else begin
          ln_we = 1'b1;
          ln_wa = lp_q[SW-1:0];
          ln_wd = ln_q;
        end
        lp_we   = 1'b1;
        lp_wa   = ln_q[SW-1:0];
        lp_wd   = lp_q;
        state_d = fcl_pkg::S_MV2;
      end
      fcl_pkg::S_MV2: begin
        lp_we   = 1'b1;
        lp_wd   = tail_q;
        ln_we   = 1'b1;
        state_d = fcl_pkg::S_MV3;
      end
      fcl_pkg::S_MV3: begin
        ln_we   = 1'b1;
        ln_wa   = tail_q[SW-1:0];
        ln_wd   = {1'b0, slot_q};
        tail_d  = {1'b0, slot_q};
        state_d = fcl_pkg::S_DONE;
      end
      fcl_pkg::S_MISS: begin
        if (!commit) begin
          res_d.outcome = fcl_pkg::OUT_MISS_SKIP;
          state_d       = fcl_pkg::S_DONE;
        end else if (cnt_q == CNT_MAX) begin
          rd_addr = head_q[SW-1:0];
          state_d = fcl_pkg::S_EV1;
        end else begin
          slot_d  = cnt_q[SW-1:0];
          state_d = fcl_pkg::S_INS1;
        end
      end
      fcl_pkg::S_EV1: begin
        slot_d             = head_q[SW-1:0];
        evn_d              = bn_rd_q;
        res_d.evicted      = 1'b1;
        res_d.evicted_tag  = rec_rd_q.tag;
        res_d.evicted_hits = rec_rd_q.hits;
        head_d             = ln_rd_q;
        lp_we              = 1'b1;
        lp_wa              = ln_rd_q[SW-1:0];
        evb_d              = bucket_of(rec_rd_q.signature);
        bh_ra              = evb_d;
        state_d            = fcl_pkg::S_EV2;
      end
      fcl_pkg::S_EV2: begin
        if (bh_rd_q == {1'b0, slot_q}) begin
          bh_we   = 1'b1;
          bh_wa   = evb_q;
          bh_wd   = evn_q;
          state_d = fcl_pkg::S_INS1;
        end else begin
          ptr_d   = bh_rd_q;
          rd_addr = bh_rd_q[SW-1:0];
          state_d = fcl_pkg::S_EV3;
        end
      end
      fcl_pkg::S_EV3: begin
        if (bn_rd_q == {1'b0, slot_q}) begin
          bn_we   = 1'b1;
          bn_wa   = ptr_q[SW-1:0];
          bn_wd   = evn_q;
          state_d = fcl_pkg::S_INS1;
        end else begin
          ptr_d   = bn_rd_q;
          rd_addr = bn_rd_q[SW-1:0];
        end
      end
      fcl_pkg::S_INS1: begin
        rec_we           = 1'b1;
        rec_wd.signature = it_q.signature;
        rec_wd.tag       = it_q.packet_tag;
        rec_wd.offset    = it_q.byte_offset;
        rec_wd.hits      = 32'd0;
        lp_we            = 1'b1;
        lp_wd            = tail_q;
        ln_we            = 1'b1;
        state_d          = fcl_pkg::S_INS2;
      end
      fcl_pkg::S_INS2: begin
        bn_we = 1'b1;
        bn_wd = bh_rd_q;
        bh_we = 1'b1;
        bh_wd = {1'b0, slot_q};
        if (tail_q[SW]) begin
          head_d = {1'b0, slot_q};
        end else begin
          ln_we = 1'b1;
          ln_wa = tail_q[SW-1:0];
          ln_wd = {1'b0, slot_q};
        end
        tail_d = {1'b0, slot_q};
        if (!res_q.evicted) begin
          cnt_d = cnt_q + 1'b1;
        end
        lco_d         = it_q.byte_offset;
        cip_d         = 1'b1;
        res_d.outcome = fcl_pkg::OUT_MISS_COMMIT;
        state_d       = fcl_pkg::S_DONE;
      end
      fcl_pkg::S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          out_d   = res_q;
          state_d = fcl_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    bkt_q  <= bkt_d;
    evb_q  <= evb_d;
    ptr_q  <= ptr_d;
    lp_q   <= lp_d;
    ln_q   <= ln_d;
    evn_q  <= evn_d;
    slot_q <= slot_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcl_pkg::S_CLEAR;
      clr_q   <= '0;
      head_q  <= NULLP;
      tail_q  <= NULLP;
      cnt_q   <= '0;
      lco_q   <= 16'd0;
      cip_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      lco_q   <= lco_d;
      cip_q   <= cip_d;
      ov_q    <= ov_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("entry count above table size");

  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q[SW] == tail_q[SW])
    else $error("recency list head and tail disagree on empty");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == fcl_pkg::S_DONE))
    else $error("result raised outside done state");

  a_evict_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_q.evicted) |-> (out_q.outcome == fcl_pkg::OUT_MISS_COMMIT))
    else $error("eviction without commit");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fcl_pkg::S_EV1) |-> (cnt_q == CNT_MAX))
    else $error("eviction while table not full");

endmodule

`default_nettype wire

[sv/fingerprint_cache_lru.sv]
// ----------------------------------------------------------------------------
// fingerprint_cache_lru
// LRU fingerprint cache for redundancy elimination.
//
// Input channel (in_valid_i/in_ready_o) takes one window fingerprint per item;
// output channel (out_valid_o/out_ready_i) returns exactly one result per item,
// in order. cfg_valid_i/cfg_ready_o writes min_commit_gap (reset 64).
// Entries are chained per bucket (low signature bits) and kept on a doubly
// linked recency list; each lookup walks one chain entry per cycle.
// Per item: a same-packet hit ends after the chain walk; an inter-packet hit is
// also moved to most recent; a skip ends after the gap check; a commit inserts
// the entry at its bucket head and at the list tail, and when the table is full
// it first evicts the least recent entry, walking its chain to unlink it.
// After reset the bucket heads are cleared and no item is taken meanwhile.
// A two-item queue sits in front of the engine and the result sits
// in an output register, so input is taken while a result waits; if the
// receiver stalls, the engine stops once its next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module fingerprint_cache_lru #(
  parameter int ENTRIES = 1024,
  parameter int BUCKETS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] min_commit_gap_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] signature_i,
  input  wire logic [15:0] packet_tag_i,
  input  wire logic [15:0] byte_offset_i,
  input  wire logic        first_window_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       outcome_o,
  output logic [15:0]      match_tag_o,
  output logic [15:0]      match_offset_o,
  output logic [31:0]      match_hits_o,
  output logic             evicted_o,
  output logic [15:0]      evicted_tag_o,
  output logic [31:0]      evicted_hits_o
);

  logic [15:0]    gap_q;
  fcl_pkg::item_t in_item, q_item;
  fcl_pkg::res_t  res;
  logic           q_valid, q_pop, clearing;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 16'd64;
    end else if (cfg_valid_i) begin
      gap_q <= min_commit_gap_i;
    end
  end

  assign in_item.signature    = signature_i;
  assign in_item.packet_tag   = packet_tag_i;
  assign in_item.byte_offset  = byte_offset_i;
  assign in_item.first_window = first_window_i;

  fcl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .clearing_i (clearing),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  fcl_back #(
    .ENTRIES (ENTRIES),
    .BUCKETS (BUCKETS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_gap_i   (gap_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign outcome_o      = res.outcome;
  assign match_tag_o    = res.match_tag;
  assign match_offset_o = res.match_offset;
  assign match_hits_o   = res.match_hits;
  assign evicted_o      = res.evicted;
  assign evicted_tag_o  = res.evicted_tag;
  assign evicted_hits_o = res.evicted_hits;

endmodule

`default_nettype wire
